[rtl/basr_pkg.sv]
// Package: shared types, codes and colour remap for the bitmap attribute screen renderer.
`default_nettype none

package basr_pkg;

	typedef logic [1:0]  kind_t;
	typedef logic [15:0] addr_t;
	typedef logic [7:0]  byte_t;
	typedef logic [8:0]  pix_x_t;
	typedef logic [7:0]  pix_y_t;
	typedef logic [3:0]  color_t;
	typedef logic [4:0]  period_t;
	typedef logic [12:0] off_t;

	// Request kinds
	localparam kind_t KIND_MEM  = 2'd0;
	localparam kind_t KIND_PORT = 2'd1;
	localparam kind_t KIND_TICK = 2'd2;

	// Result kinds
	localparam logic RK_PIXEL  = 1'b0;
	localparam logic RK_BORDER = 1'b1;

	localparam int unsigned STORE_DEPTH = 6912;
	localparam logic [13:0] STORE_LIMIT = 14'h1B00;
	localparam period_t     FLASH_RESET = 5'd25;
	localparam pix_x_t      X_ORIGIN    = 9'd32;
	localparam pix_y_t      Y_ORIGIN    = 8'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_CAPT,
		ST_EMIT,
		ST_BORDER
	} state_t;

	// GRB to RGB swap; bright black folds onto black
	function automatic color_t remap(input color_t c);
		color_t r;
		r = {c[3], c[1], c[2], c[0]};
		if (c == 4'd8) begin
			r = 4'd0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/basr_if.sv]
// Interfaces: request, result and configuration channels.
`default_nettype none

interface basr_req_if import basr_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	addr_t address;
	byte_t data;

	modport source (output valid, kind, address, data, input ready);
	modport sink   (input valid, kind, address, data, output ready);
endinterface

interface basr_rsp_if import basr_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   result_kind;
	pix_x_t pixel_x;
	pix_y_t pixel_y;
	color_t color;
	logic   last;

	modport source (output valid, result_kind, pixel_x, pixel_y, color, last, input ready);
	modport sink   (input valid, result_kind, pixel_x, pixel_y, color, last, output ready);
endinterface

interface basr_cfg_if import basr_pkg::*; ();
	logic    valid;
	logic    ready;
	period_t data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/bitmap_attribute_screen_renderer.sv]
// Top level: screen store, flash timer and pixel sequencer of the screen renderer.
//
// Usage. Requests arrive on req (valid/ready): a memory write, a port write or a
// frame tick. Results leave on rsp (valid/ready) through one output register, so
// a new request may be taken while the final result of the last one still waits.
// cfg writes flash_period and is always ready.
// Sequence. A request is taken in the idle state only; one request is worked at a
// time. Each 8-pixel line needs one registered read of the screen store RAM and
// then one pixel a cycle while the output register is free: a bitmap write is
// decoded, its attribute byte is read and its 8 pixels follow; an attribute write
// is decoded, then 8 lines are drawn in turn, each a read of the single read port
// and 8 pixels through the output register. A border update is decoded and then
// emits one border result; a frame tick and an ignored request are decoded only.
// Reset. After arst_n the store is zeroed by a clearing pass over all 6912 bytes,
// one byte a cycle; req.ready stays low meanwhile, cfg writes are taken as ever.
// Stall. While a result waits and rsp.ready is low the sequencer holds at the
// current pixel, with no loss or repeat of any result.
`default_nettype none

module bitmap_attribute_screen_renderer import basr_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	basr_req_if.sink  req,
	basr_rsp_if.source rsp,
	basr_cfg_if.sink  cfg
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);

	state_t state_q, state_d;

	// Latched request
	kind_t kind_q;
	addr_t addr_q;
	byte_t data_q;

	// Line being drawn
	logic  is_attr_q;
	off_t  line_off_q;
	byte_t attr_q;
	byte_t bits_q;
	logic [2:0] pix_q;

	// Flash timer
	period_t period_q;
	period_t flash_cnt_q;
	logic    flash_phase_q;
	logic    first_q;

	logic [AW-1:0] clr_cnt_q;

	// Output register
	logic   rsp_valid_q;
	logic   rsp_kind_q;
	pix_x_t rsp_x_q;
	pix_y_t rsp_y_q;
	color_t rsp_color_q;
	logic   rsp_last_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	byte_t         ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	byte_t         ram_rdata;

	// Sequencer decode
	logic slot_free;
	logic req_acc;
	logic req_store;
	logic q_store;
	logic q_bmp;
	off_t q_off;
	off_t q_aoff;
	off_t q_abase;
	logic emit_pix;
	logic emit_border;
	logic line_end;
	logic more_lines;
	logic tick;

	// Pixel datapath
	logic   pix_bit;
	color_t pix_color;
	logic [7:0] row;
	period_t cnt_inc;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// Store window is 0x4000..0x5AFF
	assign req_store = (req.kind == KIND_MEM) && (req.address[15:14] == 2'b01)
		&& (req.address[13:0] < STORE_LIMIT);
	assign q_store = (kind_q == KIND_MEM) && (addr_q[15:14] == 2'b01)
		&& (addr_q[13:0] < STORE_LIMIT);
	assign q_off   = addr_q[12:0];
	assign q_bmp   = (q_off[12:11] != 2'b11);
	// Attribute cell of a bitmap byte
	assign q_aoff  = {2'b11, 1'b0, q_off[12:11], q_off[7:0]};
	// First bitmap line of an attribute cell
	assign q_abase = {q_off[9:8], 3'b000, q_off[7:0]};

	assign line_end   = (pix_q == 3'd7);
	assign more_lines = is_attr_q && (line_off_q[10:8] != 3'd7);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (q_store) begin
					state_d = ST_CAPT;
				end else if (kind_q == KIND_PORT && !addr_q[0]) begin
					state_d = ST_BORDER;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CAPT: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && line_end) begin
					state_d = more_lines ? ST_CAPT : ST_IDLE;
				end
			end
			ST_BORDER: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ram_re      = 1'b0;
		ram_raddr   = '0;
		emit_pix    = 1'b0;
		emit_border = 1'b0;
		tick        = 1'b0;
		unique case (state_q)
			ST_DECODE: begin
				ram_re    = q_store;
				ram_raddr = q_bmp ? q_aoff : q_abase;
				tick      = (kind_q == KIND_TICK);
			end
			ST_EMIT: begin
				emit_pix = slot_free;
				if (slot_free && line_end && more_lines) begin
					ram_re    = 1'b1;
					ram_raddr = line_off_q + 13'h100;
				end
			end
			ST_BORDER: begin
				emit_border = slot_free;
			end
			default: begin
			end
		endcase
	end

	// Store writes: clearing pass, or the byte of an accepted memory write into the store window
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = req.address[12:0];
		ram_wdata = req.data;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (req_acc && req_store) begin
			ram_we = 1'b1;
		end
	end

	basr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Pixel colour: set bit shows ink, clear shows paper, flash inverts with the phase
	assign pix_bit   = bits_q[3'd7 - pix_q] ^ (attr_q[7] & flash_phase_q);
	assign pix_color = remap({attr_q[6], pix_bit ? attr_q[2:0] : attr_q[5:3]});
	assign row       = {line_off_q[12:11], line_off_q[7:5], line_off_q[10:8]};
	assign cnt_inc   = flash_cnt_q + 5'd1;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			period_q      <= FLASH_RESET;
			flash_cnt_q   <= '0;
			flash_phase_q <= 1'b0;
			first_q       <= 1'b1;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cfg.valid) begin
				period_q <= cfg.data;
			end
			if (tick) begin
				if (cnt_inc >= period_q || first_q) begin
					flash_cnt_q   <= '0;
					first_q       <= 1'b0;
					flash_phase_q <= !flash_phase_q;
				end else begin
					flash_cnt_q <= cnt_inc;
				end
			end
			if (emit_pix || emit_border) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q <= req.kind;
			addr_q <= req.address;
			data_q <= req.data;
		end
		if (state_q == ST_DECODE && q_store) begin
			is_attr_q  <= !q_bmp;
			line_off_q <= q_bmp ? q_off : q_abase;
		end
		if (state_q == ST_CAPT) begin
			pix_q <= '0;
			if (is_attr_q) begin
				bits_q <= ram_rdata;
				attr_q <= data_q;
			end else begin
				bits_q <= data_q;
				attr_q <= ram_rdata;
			end
		end
		if (emit_pix) begin
			pix_q       <= pix_q + 3'd1;
			rsp_kind_q  <= RK_PIXEL;
			rsp_x_q     <= X_ORIGIN + {1'b0, line_off_q[4:0], pix_q};
			rsp_y_q     <= Y_ORIGIN + row;
			rsp_color_q <= pix_color;
			rsp_last_q  <= line_end && !more_lines;
			if (line_end && more_lines) begin
				line_off_q <= line_off_q + 13'h100;
			end
		end
		if (emit_border) begin
			rsp_kind_q  <= RK_BORDER;
			rsp_x_q     <= '0;
			rsp_y_q     <= '0;
			rsp_color_q <= remap({1'b0, data_q[2:0]});
			rsp_last_q  <= 1'b1;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.pixel_x     = rsp_x_q;
	assign rsp.pixel_y     = rsp_y_q;
	assign rsp.color       = rsp_color_q;
	assign rsp.last        = rsp_last_q;

endmodule

`default_nettype wire

[rtl/basr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module basr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 6912,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
